// ===== src/fmpd_pkg.sv =====
// Shared constants and types for the FM polar discriminator with decimation.
`default_nettype none
package fmpd_pkg;

   // Default widths of the sample and angle formats.
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 13;

   // Fixed port widths.
   localparam int FIELD_W = 16;
   localparam int CFG_W   = 8;

   // Saturation works on a magnitude zero-extended to this width.
   localparam int SAT_W = 18;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Decimation factor after reset.
   localparam logic [CFG_W-1:0] DECIM_RESET = 8'd1;

   // Output limits.
   localparam logic [SAT_W-1:0] POS_LIMIT = 18'd32767;
   localparam logic [SAT_W-1:0] NEG_LIMIT = 18'd32768;
   localparam logic [FIELD_W-1:0] POS_SAT = 16'h7FFF;
   localparam logic [FIELD_W-1:0] NEG_SAT = 16'h8000;

   // Divider sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_FINISH
   } back_state_type;

endpackage
`default_nettype wire

// ===== src/fm_polar_discriminator_decimated.sv =====
// Top level of the decimating FM polar discriminator.
// Each accepted I/Q transaction is multiplied by the conjugate of the previous sample; one
// product in every decimation period (the first after reset, then every
// csr_decimation_factor samples, 0 counting as 1) is turned into a phase step in units of
// pi/4 = 2^ANGLE_FRAC_BITS, saturated to 16 bits, with +pi/2 for a zero vector. Samples
// that yield no output are taken one per clock while the input is not stalled. A kept
// product passes a registered multiply stage and a two-entry queue into a restoring
// divider that produces one quotient bit per cycle and takes the next product only once
// its result is in the output register; the input keeps flowing until the queue is full
// and a product waits in the multiply stage. Write the decimation factor only while the
// block is idle.
`default_nettype none
module fm_polar_discriminator_decimated
   import fmpd_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [FIELD_W-1:0] req_i_sample,
   input  wire logic [FIELD_W-1:0] req_q_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [FIELD_W-1:0]      rsp_phase_step,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CFG_W-1:0]   csr_decimation_factor
);

   localparam int PW = 2 * SAMPLE_BITS + 1;

   logic          push_valid;
   logic [PW-1:0] push_re;
   logic [PW-1:0] push_im;
   logic          queue_full;
   logic          job_valid;
   logic          job_pop;
   logic [2*PW-1:0] job_data;

   assign csr_ready = 1'b1;

   fmpd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_i      (req_i_sample[SAMPLE_BITS-1:0]),
      .req_q      (req_q_sample[SAMPLE_BITS-1:0]),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_decimation_factor),
      .push_valid (push_valid),
      .push_re    (push_re),
      .push_im    (push_im),
      .queue_full (queue_full)
   );

   fmpd_queue #(
      .WIDTH(2 * PW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_re, push_im}),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_data  (job_data),
      .not_empty (job_valid)
   );

   fmpd_back #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_re    (job_data[2*PW-1:PW]),
      .job_im    (job_data[PW-1:0]),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_phase (rsp_phase_step)
   );

   // The divider never takes a job from an empty queue.
   assert property (@(posedge clock) disable iff (reset) job_pop |-> job_valid)
      else $error("divider popped an empty queue");

   // A stalled input means the product stage is waiting on a full queue.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> (push_valid && queue_full))
      else $error("input stalled without a full queue");

   // A product waiting on a full queue is still there next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && queue_full) |=> push_valid)
      else $error("product lost while the queue was full");

endmodule
`default_nettype wire

// ===== src/fmpd_front.sv =====
// Front end: sample intake, decimation count and conjugate product.
`default_nettype none
module fmpd_front
   import fmpd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_i,
   input  wire logic signed [SAMPLE_BITS-1:0] req_q,
   input  wire logic                          csr_valid,
   input  wire logic [CFG_W-1:0]              csr_data,
   output logic                               push_valid,
   output logic signed [2*SAMPLE_BITS:0]      push_re,
   output logic signed [2*SAMPLE_BITS:0]      push_im,
   input  wire logic                          queue_full
);

   localparam int PRODW = 2 * SAMPLE_BITS;
   localparam int PW    = PRODW + 1;

   logic [CFG_W-1:0]              decim_ff, decim_in;
   logic                          have_prev_ff, have_prev_in;
   logic signed [SAMPLE_BITS-1:0] prev_i_ff, prev_i_in;
   logic signed [SAMPLE_BITS-1:0] prev_q_ff, prev_q_in;
   logic [CFG_W-1:0]              skip_ff, skip_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [PRODW-1:0]       p_ii_ff, p_ii_in;
   logic signed [PRODW-1:0]       p_qq_ff, p_qq_in;
   logic signed [PRODW-1:0]       p_qi_ff, p_qi_in;
   logic signed [PRODW-1:0]       p_iq_ff, p_iq_in;
   logic                          accept;
   logic                          fire;
   logic [CFG_W-1:0]              decim_eff;

   // Hold the sample while the product register cannot drain.
   assign req_stall = s1_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign fire      = accept && have_prev_ff && (skip_ff == '0);
   assign decim_eff = (decim_ff == '0) ? CFG_W'(1) : decim_ff;

   // Register write and decimation countdown.
   always_comb begin
      decim_in = csr_valid ? csr_data : decim_ff;
      skip_in  = skip_ff;
      if (fire) begin
         skip_in = decim_eff - CFG_W'(1);
      end else if (accept && have_prev_ff) begin
         skip_in = skip_ff - CFG_W'(1);
      end
      have_prev_in = have_prev_ff || accept;
      prev_i_in    = accept ? req_i : prev_i_ff;
      prev_q_in    = accept ? req_q : prev_q_ff;
   end

   // The four partial products of the sample times the conjugate of its predecessor.
   always_comb begin
      p_ii_in = req_i * prev_i_ff;
      p_qq_in = req_q * prev_q_ff;
      p_qi_in = req_q * prev_i_ff;
      p_iq_in = req_i * prev_q_ff;
      if (fire) begin
         s1_valid_in = 1'b1;
      end else if (!queue_full) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff     <= DECIM_RESET;
         have_prev_ff <= 1'b0;
         prev_i_ff    <= '0;
         prev_q_ff    <= '0;
         skip_ff      <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         decim_ff     <= decim_in;
         have_prev_ff <= have_prev_in;
         prev_i_ff    <= prev_i_in;
         prev_q_ff    <= prev_q_in;
         skip_ff      <= skip_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         p_ii_ff <= p_ii_in;
         p_qq_ff <= p_qq_in;
         p_qi_ff <= p_qi_in;
         p_iq_ff <= p_iq_in;
      end
   end

   // Real and imaginary parts of the product.
   assign push_valid = s1_valid_ff;
   assign push_re    = PW'(p_ii_ff) + PW'(p_qq_ff);
   assign push_im    = PW'(p_qi_ff) - PW'(p_iq_ff);

endmodule
`default_nettype wire

// ===== src/fmpd_queue.sv =====
// Short queue that decouples the product front end from the divider.
`default_nettype none
module fmpd_queue
   import fmpd_pkg::*;
#(
   parameter int WIDTH = 2 * (2 * SAMPLE_BITS_DEF + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/fmpd_back.sv =====
// Back end: rounded restoring division for the fast atan2 and the output register.
`default_nettype none
module fmpd_back
   import fmpd_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire logic signed [2*SAMPLE_BITS:0] job_re,
   input  wire logic signed [2*SAMPLE_BITS:0] job_im,
   output logic                               job_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [FIELD_W-1:0]                 rsp_phase
);

   localparam int PW    = 2 * SAMPLE_BITS + 1;
   localparam int AW    = 2 * SAMPLE_BITS;
   localparam int DENW  = AW + 1;
   localparam int MW    = AW + 3;
   localparam int NW    = AW + ANGLE_FRAC_BITS + 5;
   localparam int DW    = AW + 2;
   localparam int MAGW  = ANGLE_FRAC_BITS + 3;
   localparam int CNT_W = $clog2(MAGW);

   back_state_type   state_ff, state_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [MAGW-1:0]  low_ff, low_in;
   logic [DW-1:0]    div_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             neg_ff;
   logic             zero_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_phase_ff, rsp_phase_in;

   logic             out_load;
   logic             last_step;
   logic [PW-1:0]    im_abs;
   logic [PW-1:0]    re_abs;
   logic             im_neg;
   logic             re_neg;
   logic [AW-1:0]    a_mag;
   logic [AW-1:0]    x_mag;
   logic [DENW-1:0]  den;
   logic [MW-1:0]    num_base;
   logic [NW-1:0]    dividend;
   logic [DW:0]      rem_sh;
   logic             q_bit;
   logic [MAGW-1:0]  mag;
   logic [SAT_W-1:0] mag_ext;

   // Operands of the division, formed as a job leaves the queue.
   always_comb begin
      im_neg   = job_im[PW-1];
      re_neg   = job_re[PW-1];
      im_abs   = im_neg ? PW'(-job_im) : PW'(job_im);
      re_abs   = re_neg ? PW'(-job_re) : PW'(job_re);
      a_mag    = im_abs[AW-1:0];
      x_mag    = re_abs[AW-1:0];
      den      = DENW'(a_mag) + DENW'(x_mag);
      num_base = re_neg ? (MW'(a_mag) << 1) + (MW'(x_mag) << 2) : (MW'(a_mag) << 1);
      dividend = (NW'(num_base) << (ANGLE_FRAC_BITS + 1)) + NW'(den);
   end

   // One quotient bit a cycle.
   always_comb begin
      rem_sh = {rem_ff, low_ff[MAGW-1]};
      q_bit  = (rem_sh >= {1'b0, div_ff});
   end

   assign last_step = (count_ff == CNT_W'(MAGW - 1));
   assign out_load  = (state_ff == BK_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (last_step) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs and datapath updates.
   always_comb begin
      job_pop  = 1'b0;
      rem_in   = rem_ff;
      low_in   = low_ff;
      count_in = count_ff;
      case (state_ff)
         BK_IDLE: begin
            job_pop  = job_valid;
            rem_in   = dividend[NW-1:MAGW];
            low_in   = dividend[MAGW-1:0];
            count_in = '0;
         end
         BK_DIVIDE: begin
            rem_in   = q_bit ? DW'(rem_sh - {1'b0, div_ff}) : rem_sh[DW-1:0];
            low_in   = {low_ff[MAGW-2:0], q_bit};
            count_in = count_ff + CNT_W'(1);
         end
         BK_FINISH: begin
            job_pop = 1'b0;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // Sign, the zero-vector case and saturation to the output format.
   always_comb begin
      mag     = zero_ff ? MAGW'(2 << ANGLE_FRAC_BITS) : low_ff;
      mag_ext = SAT_W'(mag);
      if (!neg_ff) begin
         rsp_phase_in = (mag_ext > POS_LIMIT) ? POS_SAT : FIELD_W'(mag_ext);
      end else begin
         rsp_phase_in = (mag_ext > NEG_LIMIT) ? NEG_SAT : FIELD_W'(-mag_ext);
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      if (job_pop) begin
         div_ff  <= {den, 1'b0};
         neg_ff  <= im_neg;
         zero_ff <= !re_neg && (den == '0);
      end
      if (out_load) begin
         rsp_phase_ff <= rsp_phase_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;

endmodule
`default_nettype wire
